// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int QIDX_W      = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(WRITE_DEPTH + 1);

  localparam int PH_W = 5;

  // waveform phases
  localparam logic [PH_W-1:0] PH_IDLE = 5'd0;
  localparam logic [PH_W-1:0] PH_S1   = 5'd1;
  localparam logic [PH_W-1:0] PH_S2   = 5'd2;
  localparam logic [PH_W-1:0] PH_S3   = 5'd3;
  localparam logic [PH_W-1:0] PH_R0   = 5'd4;
  localparam logic [PH_W-1:0] PH_R1   = 5'd5;
  localparam logic [PH_W-1:0] PH_R2   = 5'd6;
  localparam logic [PH_W-1:0] PH_R3   = 5'd7;
  localparam logic [PH_W-1:0] PH_TX   = 5'd8;
  localparam logic [PH_W-1:0] PH_ACK  = 5'd16;
  localparam logic [PH_W-1:0] PH_RXL  = 5'd24;
  localparam logic [PH_W-1:0] PH_RXH  = 5'd25;
  localparam logic [PH_W-1:0] PH_KL   = 5'd26;
  localparam logic [PH_W-1:0] PH_KH   = 5'd27;
  localparam logic [PH_W-1:0] PH_KE   = 5'd28;
  localparam logic [PH_W-1:0] PH_P0   = 5'd29;
  localparam logic [PH_W-1:0] PH_P1   = 5'd30;
  localparam logic [PH_W-1:0] PH_P2   = 5'd31;

  // byte stages (bits [2:1] of a TX / ACK phase)
  localparam logic [1:0] ST_ADDRW = 2'd0;
  localparam logic [1:0] ST_REG   = 2'd1;
  localparam logic [1:0] ST_ADDRR = 2'd2;
  localparam logic [1:0] ST_DATA  = 2'd3;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_QUEUE = 2'd3;

  // configuration register indexes
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_LIMIT   = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
  localparam logic [7:0] ACK_LIMIT_RST   = 8'd250;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_data_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       ack_timeout;
    logic       done_res;
  } out_data_t;

endpackage

// File: rtl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access
// Pin-level I2C master: register reads and queued register writes, one
// waveform phase per phase_ticks tick words, with ACK timeout abort.
// ----------------------------------------------------------------------------
// The result word of an accepted input word is registered and valid in the cycle after it.
// Throughput: one word per cycle while out_ready is high; the phase/state update is a single
//   registered pass, and the output register frees as the result is taken.
// Reset (synchronous, rst_n low): bus idle, queue empty, phase_ticks = 1,
//   ack_limit = 250; queue entries hold garbage until written.
module i2c_master_register_access (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_data_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0] phase_ticks_r;
  logic [7:0] ack_limit_r;

  logic [i2cm_pkg::PH_W-1:0]    phase_r, phase_nxt;
  logic [2:0]                   bit_index_r, bit_index_nxt;
  logic [7:0]                   shift_r, shift_nxt;
  logic [7:0]                   bytes_left_r, bytes_left_nxt;
  logic [7:0]                   ack_polls_r, ack_polls_nxt;
  logic [7:0]                   tick_count_r, tick_count_nxt;
  logic                         is_read_r, is_read_nxt;
  logic [6:0]                   saved_dev_r, saved_dev_nxt;
  logic [7:0]                   saved_reg_r, saved_reg_nxt;
  logic [i2cm_pkg::QFILL_W-1:0] queue_fill_r, queue_fill_nxt;

  logic [7:0] queue_mem [i2cm_pkg::WRITE_DEPTH];
  logic [7:0] q_rd_r;

  logic                out_valid_r;
  i2cm_pkg::out_data_t out_data_r, out_nxt;

  logic in_fire;
  logic q_wr;
  logic scl_c, sda_c, drv_c;
  logic in_tx, in_ack;
  logic held;
  logic [1:0] stage;
  logic [7:0] bl_eff;
  logic [8:0] q_idx;
  logic [7:0] rx_shift;
  logic tmo_c;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_tx  = (phase_r[4:3] == 2'b01);
  assign in_ack = (phase_r[4:3] == 2'b10);
  assign stage  = phase_r[2:1];

  // line levels of the current phase
  always_comb begin
    scl_c = 1'b1;
    sda_c = 1'b1;
    drv_c = 1'b1;
    if (in_tx) begin
      scl_c = phase_r[0];
      sda_c = shift_r[7];
    end else if (in_ack) begin
      scl_c = phase_r[0];
      drv_c = 1'b0;
    end else begin
      case (phase_r)
        i2cm_pkg::PH_S1, i2cm_pkg::PH_R1: ;
        i2cm_pkg::PH_S2, i2cm_pkg::PH_R2: sda_c = 1'b0;
        i2cm_pkg::PH_S3, i2cm_pkg::PH_R3: begin
          scl_c = 1'b0;
          sda_c = 1'b0;
        end
        i2cm_pkg::PH_R0:  scl_c = 1'b0;
        i2cm_pkg::PH_RXL: begin
          scl_c = 1'b0;
          drv_c = 1'b0;
        end
        i2cm_pkg::PH_RXH: drv_c = 1'b0;
        i2cm_pkg::PH_KL, i2cm_pkg::PH_KE: begin
          scl_c = 1'b0;
          sda_c = (bytes_left_r <= 8'd1);
        end
        i2cm_pkg::PH_KH: sda_c = (bytes_left_r <= 8'd1);
        i2cm_pkg::PH_P0: begin
          scl_c = 1'b0;
          sda_c = 1'b0;
        end
        i2cm_pkg::PH_P1: sda_c = 1'b0;
        i2cm_pkg::PH_P2: ;
        default: drv_c = 1'b0;
      endcase
    end
  end

  assign held     = ({1'b0, tick_count_r} + 9'd1) >= {1'b0, phase_ticks_r};
  assign rx_shift = {shift_r[6:0], in_data.sda_in};

  // bytes left after an ACKed data byte, and the queue slot it selects
  assign bl_eff = (stage == i2cm_pkg::ST_DATA && bytes_left_r != 8'd0) ?
                  bytes_left_r - 8'd1 : bytes_left_r;
  assign q_idx  = {{(9 - i2cm_pkg::QFILL_W){1'b0}}, queue_fill_r} - {1'b0, bl_eff};

  always_comb begin
    phase_nxt      = phase_r;
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    ack_polls_nxt  = ack_polls_r;
    tick_count_nxt = tick_count_r;
    is_read_nxt    = is_read_r;
    saved_dev_nxt  = saved_dev_r;
    saved_reg_nxt  = saved_reg_r;
    queue_fill_nxt = queue_fill_r;
    q_wr           = 1'b0;
    tmo_c          = 1'b0;
    out_nxt        = '0;
    out_nxt.scl_level = scl_c;
    out_nxt.sda_level = sda_c;
    out_nxt.sda_drive = drv_c;

    case (in_data.cmd)
      i2cm_pkg::CMD_READ, i2cm_pkg::CMD_WRITE: begin
        if (phase_r == i2cm_pkg::PH_IDLE) begin
          saved_dev_nxt  = in_data.dev_addr;
          saved_reg_nxt  = in_data.reg_addr;
          is_read_nxt    = (in_data.cmd == i2cm_pkg::CMD_READ);
          bytes_left_nxt = (in_data.cmd == i2cm_pkg::CMD_READ) ? in_data.byte_count :
                           8'(queue_fill_r);
          phase_nxt      = i2cm_pkg::PH_S1;
          tick_count_nxt = '0;
        end
      end
      i2cm_pkg::CMD_QUEUE: begin
        if (phase_r == i2cm_pkg::PH_IDLE &&
            queue_fill_r < i2cm_pkg::QFILL_W'(i2cm_pkg::WRITE_DEPTH)) begin
          q_wr           = 1'b1;
          queue_fill_nxt = queue_fill_r + i2cm_pkg::QFILL_W'(1);
        end
      end
      default: begin
        if (phase_r != i2cm_pkg::PH_IDLE) begin
          if (!held) begin
            tick_count_nxt = tick_count_r + 8'd1;
          end else begin
            tick_count_nxt = '0;  // every held branch below enters a phase or keeps polling
            if (in_ack && phase_r[0]) begin
              if (!in_data.sda_in) begin
                case (stage)
                  i2cm_pkg::ST_ADDRW: begin
                    shift_nxt     = saved_reg_r;
                    bit_index_nxt = '0;
                    phase_nxt     = i2cm_pkg::PH_TX + 5'd2;
                  end
                  i2cm_pkg::ST_ADDRR: begin
                    if (bytes_left_r == 8'd0) begin
                      if (!is_read_r) queue_fill_nxt = '0;
                      phase_nxt = i2cm_pkg::PH_P0;
                    end else begin
                      shift_nxt     = '0;
                      bit_index_nxt = '0;
                      phase_nxt     = i2cm_pkg::PH_RXL;
                    end
                  end
                  default: begin
                    // register byte or data byte ACKed
                    if (stage == i2cm_pkg::ST_REG && is_read_r) begin
                      phase_nxt = i2cm_pkg::PH_R0;
                    end else begin
                      bytes_left_nxt = bl_eff;
                      if (bl_eff == 8'd0 || bl_eff > 8'(queue_fill_r) ||
                          q_idx >= 9'(i2cm_pkg::WRITE_DEPTH)) begin
                        if (!is_read_r) queue_fill_nxt = '0;
                        phase_nxt = i2cm_pkg::PH_P0;
                      end else begin
                        shift_nxt     = q_rd_r;
                        bit_index_nxt = '0;
                        phase_nxt     = i2cm_pkg::PH_TX + 5'd6;
                      end
                    end
                  end
                endcase
              end else if (ack_polls_r >= ack_limit_r) begin
                tmo_c = 1'b1;
                if (!is_read_r) queue_fill_nxt = '0;
                phase_nxt = i2cm_pkg::PH_P0;
              end else begin
                ack_polls_nxt  = ack_polls_r + 8'd1;
                tick_count_nxt = tick_count_r;
              end
            end else if (in_tx) begin
              if (phase_r[0]) begin
                shift_nxt     = {shift_r[6:0], 1'b0};
                bit_index_nxt = bit_index_r + 3'd1;
                if (bit_index_r == 3'd7) begin
                  ack_polls_nxt = '0;
                  phase_nxt     = phase_r + 5'd7;  // to the ACK low phase of this stage
                end else begin
                  phase_nxt = phase_r - 5'd1;
                end
              end else begin
                phase_nxt = phase_r + 5'd1;
              end
            end else if (in_ack) begin
              phase_nxt = phase_r + 5'd1;
            end else begin
              case (phase_r)
                i2cm_pkg::PH_S1:  phase_nxt = i2cm_pkg::PH_S2;
                i2cm_pkg::PH_S2:  phase_nxt = i2cm_pkg::PH_S3;
                i2cm_pkg::PH_S3: begin
                  shift_nxt     = {saved_dev_r, 1'b0};
                  bit_index_nxt = '0;
                  phase_nxt     = i2cm_pkg::PH_TX;
                end
                i2cm_pkg::PH_R0:  phase_nxt = i2cm_pkg::PH_R1;
                i2cm_pkg::PH_R1:  phase_nxt = i2cm_pkg::PH_R2;
                i2cm_pkg::PH_R2:  phase_nxt = i2cm_pkg::PH_R3;
                i2cm_pkg::PH_R3: begin
                  shift_nxt     = {saved_dev_r, 1'b1};
                  bit_index_nxt = '0;
                  phase_nxt     = i2cm_pkg::PH_TX + 5'd4;
                end
                i2cm_pkg::PH_RXL: phase_nxt = i2cm_pkg::PH_RXH;
                i2cm_pkg::PH_RXH: begin
                  shift_nxt     = rx_shift;
                  bit_index_nxt = bit_index_r + 3'd1;
                  if (bit_index_r == 3'd7) begin
                    out_nxt.read_byte  = rx_shift;
                    out_nxt.read_valid = 1'b1;
                    out_nxt.read_last  = (bytes_left_r <= 8'd1);
                    phase_nxt          = i2cm_pkg::PH_KL;
                  end else begin
                    phase_nxt = i2cm_pkg::PH_RXL;
                  end
                end
                i2cm_pkg::PH_KL:  phase_nxt = i2cm_pkg::PH_KH;
                i2cm_pkg::PH_KH:  phase_nxt = i2cm_pkg::PH_KE;
                i2cm_pkg::PH_KE: begin
                  if (bytes_left_r <= 8'd1) begin
                    bytes_left_nxt = '0;
                    if (!is_read_r) queue_fill_nxt = '0;
                    phase_nxt = i2cm_pkg::PH_P0;
                  end else begin
                    bytes_left_nxt = bytes_left_r - 8'd1;
                    shift_nxt      = '0;
                    phase_nxt      = i2cm_pkg::PH_RXL;
                  end
                end
                i2cm_pkg::PH_P0:  phase_nxt = i2cm_pkg::PH_P1;
                i2cm_pkg::PH_P1:  phase_nxt = i2cm_pkg::PH_P2;
                i2cm_pkg::PH_P2: begin
                  out_nxt.done_res = 1'b1;
                  phase_nxt        = i2cm_pkg::PH_IDLE;
                end
                default: phase_nxt = i2cm_pkg::PH_IDLE;
              endcase
            end
          end
        end
      end
    endcase

    out_nxt.ack_timeout = tmo_c;
    out_nxt.busy_res    = (phase_nxt != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cm_pkg::PHASE_TICKS_RST;
      ack_limit_r   <= i2cm_pkg::ACK_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        i2cm_pkg::REG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        i2cm_pkg::REG_ACK_LIMIT:   ack_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cm_pkg::PH_IDLE;
      bit_index_r  <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      ack_polls_r  <= '0;
      tick_count_r <= '0;
      is_read_r    <= 1'b0;
      saved_dev_r  <= '0;
      saved_reg_r  <= '0;
      queue_fill_r <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      ack_polls_r  <= ack_polls_nxt;
      tick_count_r <= tick_count_nxt;
      is_read_r    <= is_read_nxt;
      saved_dev_r  <= saved_dev_nxt;
      saved_reg_r  <= saved_reg_nxt;
      queue_fill_r <= queue_fill_nxt;
    end
  end

  // write queue, no reset
  always_ff @(posedge clk) begin
    if (in_fire && q_wr) begin
      queue_mem[queue_fill_r[i2cm_pkg::QIDX_W-1:0]] <= in_data.write_byte;
    end
  end

  // next data byte, read ahead: the slot is fixed from the ACK low phase on
  always_ff @(posedge clk) begin
    q_rd_r <= queue_mem[q_idx[i2cm_pkg::QIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queue_fill_r <= i2cm_pkg::QFILL_W'(i2cm_pkg::WRITE_DEPTH))
    else $error("write queue fill beyond depth");

  a_idle_bit_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2cm_pkg::PH_IDLE |-> bit_index_r == 3'd0)
    else $error("bit index not cleared while idle");

  a_timeout_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && tmo_c) |=> (phase_r == i2cm_pkg::PH_P0 && out_valid_r
                            && out_data_r.ack_timeout))
    else $error("ACK timeout did not start a stop");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

// File: tb/i2cm_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_tb_pkg
// Line-level predictor and result scoreboard for the I2C register access
// master: tracks the waveform phase, the write queue and the ACK polling,
// and checks every result word field by field.
// ----------------------------------------------------------------------------
package i2cm_tb_pkg;

  class i2c_line_predictor;

    logic [7:0]                phase_ticks;
    logic [7:0]                ack_limit;
    logic [i2cm_pkg::PH_W-1:0] phase;
    int unsigned               bit_index;
    int unsigned               tick_count;
    int unsigned               ack_polls;
    int unsigned               bytes_left;
    int unsigned               fill;
    logic [7:0]                shift_reg;
    logic                      is_read;
    logic [6:0]                saved_dev;
    logic [7:0]                saved_reg;
    logic [7:0]                wq [i2cm_pkg::WRITE_DEPTH];
    i2cm_pkg::out_data_t       expected_lines [$];
    int                        errors;

    function new();
      errors = 0;
      phase_ticks = i2cm_pkg::PHASE_TICKS_RST;
      ack_limit   = i2cm_pkg::ACK_LIMIT_RST;
      phase       = i2cm_pkg::PH_IDLE;
      bit_index   = 0;
      tick_count  = 0;
      ack_polls   = 0;
      bytes_left  = 0;
      fill        = 0;
      shift_reg   = '0;
      is_read     = 1'b0;
      saved_dev   = '0;
      saved_reg   = '0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == i2cm_pkg::REG_PHASE_TICKS) begin
        phase_ticks = value;
      end else begin
        ack_limit = value;
      end
    endfunction

    function bit busy();
      return phase != i2cm_pkg::PH_IDLE;
    endfunction

    // high half of an ACK bit: the slave is being polled
    function bit awaiting_ack();
      return phase >= i2cm_pkg::PH_ACK && phase < i2cm_pkg::PH_RXL && phase[0];
    endfunction

    function void enter(logic [i2cm_pkg::PH_W-1:0] ph);
      phase = ph;
      tick_count = 0;
    endfunction

    function void send_byte(logic [1:0] stage, logic [7:0] value);
      shift_reg = value;
      bit_index = 0;
      enter(i2cm_pkg::PH_TX | {stage, 1'b0});
    endfunction

    function void go_stop();
      if (!is_read) fill = 0;
      enter(i2cm_pkg::PH_P0);
    endfunction

    function void send_next_data();
      if (bytes_left == 0 || bytes_left > fill) begin
        go_stop();
      end else begin
        send_byte(i2cm_pkg::ST_DATA, wq[fill - bytes_left]);
      end
    endfunction

    function void after_ack(logic [1:0] stage);
      case (stage)
        i2cm_pkg::ST_ADDRW: send_byte(i2cm_pkg::ST_REG, saved_reg);
        i2cm_pkg::ST_REG: begin
          if (is_read) enter(i2cm_pkg::PH_R0);
          else send_next_data();
        end
        i2cm_pkg::ST_ADDRR: begin
          if (bytes_left == 0) begin
            go_stop();
          end else begin
            shift_reg = '0;
            bit_index = 0;
            enter(i2cm_pkg::PH_RXL);
          end
        end
        default: begin
          if (bytes_left > 0) bytes_left--;
          send_next_data();
        end
      endcase
    endfunction

    function void line_levels(output logic c, output logic d, output logic e);
      c = 1'b1;
      d = 1'b1;
      e = 1'b1;
      if (phase >= i2cm_pkg::PH_TX && phase < i2cm_pkg::PH_ACK) begin
        c = phase[0];
        d = shift_reg[7];
      end else if (phase >= i2cm_pkg::PH_ACK && phase < i2cm_pkg::PH_RXL) begin
        c = phase[0];
        e = 1'b0;
      end else begin
        case (phase)
          i2cm_pkg::PH_S1, i2cm_pkg::PH_R1, i2cm_pkg::PH_P2: ;
          i2cm_pkg::PH_S2, i2cm_pkg::PH_R2, i2cm_pkg::PH_P1: d = 1'b0;
          i2cm_pkg::PH_S3, i2cm_pkg::PH_R3, i2cm_pkg::PH_P0: begin
            c = 1'b0;
            d = 1'b0;
          end
          i2cm_pkg::PH_R0: c = 1'b0;
          i2cm_pkg::PH_RXL: begin
            c = 1'b0;
            e = 1'b0;
          end
          i2cm_pkg::PH_RXH: e = 1'b0;
          i2cm_pkg::PH_KL, i2cm_pkg::PH_KE: begin
            c = 1'b0;
            d = (bytes_left <= 1);
          end
          i2cm_pkg::PH_KH: d = (bytes_left <= 1);
          default: e = 1'b0;
        endcase
      end
    endfunction

    // one tick while a transaction runs
    function void advance(logic sda, inout i2cm_pkg::out_data_t o);
      if (tick_count + 1 < phase_ticks) begin
        tick_count++;
      end else if (awaiting_ack()) begin
        if (!sda) begin
          after_ack(phase[2:1]);
        end else if (ack_polls >= ack_limit) begin
          o.ack_timeout = 1'b1;
          go_stop();
        end else begin
          ack_polls++;
        end
      end else if (phase >= i2cm_pkg::PH_TX && phase < i2cm_pkg::PH_ACK) begin
        if (phase[0]) begin
          shift_reg = {shift_reg[6:0], 1'b0};
          bit_index++;
          if (bit_index >= 8) begin
            bit_index = 0;
            ack_polls = 0;
            enter(i2cm_pkg::PH_ACK | {phase[2:1], 1'b0});
          end else begin
            enter(phase - 5'd1);
          end
        end else begin
          enter(phase + 5'd1);
        end
      end else if (phase >= i2cm_pkg::PH_ACK && phase < i2cm_pkg::PH_RXL) begin
        enter(phase + 5'd1);
      end else begin
        case (phase)
          i2cm_pkg::PH_S1: enter(i2cm_pkg::PH_S2);
          i2cm_pkg::PH_S2: enter(i2cm_pkg::PH_S3);
          i2cm_pkg::PH_S3: send_byte(i2cm_pkg::ST_ADDRW, {saved_dev, 1'b0});
          i2cm_pkg::PH_R0: enter(i2cm_pkg::PH_R1);
          i2cm_pkg::PH_R1: enter(i2cm_pkg::PH_R2);
          i2cm_pkg::PH_R2: enter(i2cm_pkg::PH_R3);
          i2cm_pkg::PH_R3: send_byte(i2cm_pkg::ST_ADDRR, {saved_dev, 1'b1});
          i2cm_pkg::PH_RXL: enter(i2cm_pkg::PH_RXH);
          i2cm_pkg::PH_RXH: begin
            shift_reg = {shift_reg[6:0], sda};
            bit_index++;
            if (bit_index >= 8) begin
              bit_index = 0;
              o.read_byte  = shift_reg;
              o.read_valid = 1'b1;
              o.read_last  = (bytes_left <= 1);
              enter(i2cm_pkg::PH_KL);
            end else begin
              enter(i2cm_pkg::PH_RXL);
            end
          end
          i2cm_pkg::PH_KL: enter(i2cm_pkg::PH_KH);
          i2cm_pkg::PH_KH: enter(i2cm_pkg::PH_KE);
          i2cm_pkg::PH_KE: begin
            if (bytes_left > 0) bytes_left--;
            if (bytes_left == 0) begin
              go_stop();
            end else begin
              shift_reg = '0;
              enter(i2cm_pkg::PH_RXL);
            end
          end
          i2cm_pkg::PH_P0: enter(i2cm_pkg::PH_P1);
          i2cm_pkg::PH_P1: enter(i2cm_pkg::PH_P2);
          i2cm_pkg::PH_P2: begin
            o.done_res = 1'b1;
            enter(i2cm_pkg::PH_IDLE);
          end
          default: enter(i2cm_pkg::PH_IDLE);
        endcase
      end
    endfunction

    // Returns 1 when the word had an effect on the block.
    function bit note_word(i2cm_pkg::in_data_t w);
      i2cm_pkg::out_data_t o;
      logic                c, d, e;
      bit                  eff;
      o = '0;
      eff = 1'b0;
      line_levels(c, d, e);
      o.scl_level = c;
      o.sda_level = d;
      o.sda_drive = e;
      case (w.cmd)
        i2cm_pkg::CMD_READ, i2cm_pkg::CMD_WRITE: begin
          if (phase == i2cm_pkg::PH_IDLE) begin
            eff = 1'b1;
            saved_dev  = w.dev_addr;
            saved_reg  = w.reg_addr;
            is_read    = (w.cmd == i2cm_pkg::CMD_READ);
            bytes_left = is_read ? w.byte_count : fill;
            enter(i2cm_pkg::PH_S1);
          end
        end
        i2cm_pkg::CMD_QUEUE: begin
          if (phase == i2cm_pkg::PH_IDLE && fill < i2cm_pkg::WRITE_DEPTH) begin
            eff = 1'b1;
            wq[fill] = w.write_byte;
            fill++;
          end
        end
        default: begin
          if (phase != i2cm_pkg::PH_IDLE) begin
            eff = 1'b1;
            advance(w.sda_in, o);
          end
        end
      endcase
      o.busy_res = (phase != i2cm_pkg::PH_IDLE);
      expected_lines.push_back(o);
      return eff;
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(i2cm_pkg::out_data_t got);
      i2cm_pkg::out_data_t want;
      if (expected_lines.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      want = expected_lines.pop_front();
      compare("scl_level", want.scl_level, got.scl_level);
      compare("sda_level", want.sda_level, got.sda_level);
      compare("sda_drive", want.sda_drive, got.sda_drive);
      compare("read_byte", want.read_byte, got.read_byte);
      compare("read_valid", want.read_valid, got.read_valid);
      compare("read_last", want.read_last, got.read_last);
      compare("busy_res", want.busy_res, got.busy_res);
      compare("ack_timeout", want.ack_timeout, got.ack_timeout);
      compare("done_res", want.done_res, got.done_res);
    endfunction

  endclass

endpackage

// File: tb/i2c_master_register_access_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_tb
// Drives register reads and queued writes through the master one tick word
// at a time, playing the slave on SDA (ACKs, missing ACKs, read data), and
// checks every result word against a line-level predictor. Runs a directed
// pass, then random traffic under several phase_ticks / ack_limit settings.
// ----------------------------------------------------------------------------
module i2c_master_register_access_tb;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  i2cm_pkg::in_data_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  i2cm_pkg::out_data_t out_data;
  logic                cfg_we = 1'b0;
  logic                cfg_addr = 1'b0;
  logic [7:0]          cfg_wdata = '0;

  i2cm_tb_pkg::i2c_line_predictor sb;

  int in_gap_pct     = 20;
  int out_stall_pct  = 20;
  int ack_coop       = 100;
  int busy_noise_pct = 0;
  int work_done      = 0;
  int stall_left     = 0;

  i2c_master_register_access dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  initial begin
    #80_000_000;
    $display("FAIL");
    $finish;
  end

  // mostly short idles, now and then a long one
  function automatic int idle_len(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = idle_len(out_stall_pct);
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  function automatic i2cm_pkg::in_data_t make_word(logic [1:0] cmd, logic [6:0] dev,
                                                   logic [7:0] rga, logic [7:0] cnt,
                                                   logic [7:0] wb);
    i2cm_pkg::in_data_t w;
    w.cmd        = cmd;
    w.dev_addr   = dev;
    w.reg_addr   = rga;
    w.byte_count = cnt;
    w.write_byte = wb;
    w.sda_in     = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic i2cm_pkg::in_data_t rand_word(logic [1:0] cmd, logic [7:0] cnt);
    return make_word(cmd, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), cnt,
                     8'($urandom_range(0, 255)));
  endfunction

  // slave side: pull SDA low for ACK with probability ack_coop percent, random data otherwise
  function automatic i2cm_pkg::in_data_t tick_word();
    i2cm_pkg::in_data_t w;
    w = rand_word(i2cm_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    if (sb.awaiting_ack()) w.sda_in = ($urandom_range(0, 99) >= ack_coop);
    return w;
  endfunction

  // Called at a rising edge; returns at a rising edge with valid still high
  // unless a gap follows.
  task automatic push_word(i2cm_pkg::in_data_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_word(w)) work_done++;
    gap = idle_len(in_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_to_idle();
    while (sb.busy()) begin
      if ($urandom_range(0, 99) < busy_noise_pct) begin
        push_word(rand_word(2'($urandom_range(i2cm_pkg::CMD_READ, i2cm_pkg::CMD_QUEUE)),
                            8'($urandom_range(0, 255))));
      end else begin
        push_word(tick_word());
      end
    end
  endtask

  // wait out all results, then write both registers
  task automatic set_config(logic [7:0] pt, logic [7:0] al);
    in_valid <= 1'b0;
    while (sb.expected_lines.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= i2cm_pkg::REG_PHASE_TICKS;
    cfg_wdata <= pt;
    @(posedge clk);
    cfg_addr  <= i2cm_pkg::REG_ACK_LIMIT;
    cfg_wdata <= al;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(i2cm_pkg::REG_PHASE_TICKS, pt);
    sb.set_reg(i2cm_pkg::REG_ACK_LIMIT, al);
    @(posedge clk);
  endtask

  task automatic random_transaction(int coop, int max_cnt, int max_q);
    int r, n, k;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      repeat ($urandom_range(1, 3)) push_word(tick_word());
      return;
    end
    ack_coop = ($urandom_range(0, 99) < 8) ? 0 : coop;
    if (r < 55) begin
      if (max_q > 0 && $urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 2)) begin
          push_word(rand_word(i2cm_pkg::CMD_QUEUE, 8'($urandom_range(0, 255))));
        end
      end
      if ($urandom_range(0, 15) == 0) n = $urandom_range(0, max_cnt);
      else n = $urandom_range(0, (max_cnt < 3) ? max_cnt : 3);
      push_word(rand_word(i2cm_pkg::CMD_READ, 8'(n)));
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, (max_q == i2cm_pkg::WRITE_DEPTH) ? max_q + 2 : max_q);
      end else begin
        k = $urandom_range(0, (max_q < 4) ? max_q : 4);
      end
      repeat (k) push_word(rand_word(i2cm_pkg::CMD_QUEUE, 8'($urandom_range(0, 255))));
      push_word(rand_word(i2cm_pkg::CMD_WRITE, 8'($urandom_range(0, 255))));
    end
    run_to_idle();
  endtask

  task automatic run_session(logic [7:0] pt, logic [7:0] al, int budget, int gap_pct,
                             int stall_pct, int coop, int max_cnt, int max_q);
    set_config(pt, al);
    in_gap_pct     = gap_pct;
    out_stall_pct  = stall_pct;
    busy_noise_pct = 4;
    work_done      = 0;
    while (work_done < budget) random_transaction(coop, max_cnt, max_q);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks on an idle bus do nothing; then two queued bytes are written
    push_word(make_word(i2cm_pkg::CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00));
    push_word(make_word(i2cm_pkg::CMD_TICK, 7'h7F, 8'hFF, 8'hFF, 8'hFF));
    push_word(make_word(i2cm_pkg::CMD_QUEUE, 7'h00, 8'h00, 8'h00, 8'h00));
    push_word(make_word(i2cm_pkg::CMD_QUEUE, 7'h7F, 8'hFF, 8'hFF, 8'hFF));
    push_word(make_word(i2cm_pkg::CMD_WRITE, 7'h7F, 8'hFF, 8'h00, 8'h00));
    run_to_idle();
    // zero-length read stops after the read address
    push_word(make_word(i2cm_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, 8'h00));
    run_to_idle();
    // commands while busy are dropped
    push_word(make_word(i2cm_pkg::CMD_READ, 7'h55, 8'hAA, 8'h02, 8'h00));
    push_word(make_word(i2cm_pkg::CMD_WRITE, 7'h2A, 8'h55, 8'h01, 8'h11));
    push_word(make_word(i2cm_pkg::CMD_QUEUE, 7'h2A, 8'h55, 8'h01, 8'h5A));
    push_word(make_word(i2cm_pkg::CMD_READ, 7'h01, 8'h02, 8'h03, 8'h00));
    run_to_idle();
    // write with an empty queue
    push_word(make_word(i2cm_pkg::CMD_WRITE, 7'h2A, 8'h55, 8'h00, 8'h00));
    run_to_idle();
    // fill the queue past its depth, then let the slave never ACK
    for (int i = 0; i <= i2cm_pkg::WRITE_DEPTH; i++) begin
      push_word(make_word(i2cm_pkg::CMD_QUEUE, 7'h00, 8'h00, 8'h00, 8'(i * 17)));
    end
    ack_coop = 0;
    push_word(make_word(i2cm_pkg::CMD_WRITE, 7'h01, 8'h01, 8'h00, 8'h00));
    run_to_idle();
    ack_coop = 100;
    // queue must be empty after the aborted write
    push_word(make_word(i2cm_pkg::CMD_WRITE, 7'h01, 8'h02, 8'h00, 8'h00));
    run_to_idle();
    push_word(make_word(i2cm_pkg::CMD_READ, 7'h7F, 8'h80, 8'h05, 8'h00));
    run_to_idle();

    run_session(8'd4, 8'd0, 1, 10, 10, 90, 0, 0);
    run_session(8'd1, 8'd250, 160, 30, 30, 92, 12, i2cm_pkg::WRITE_DEPTH);
    run_session(8'd0, 8'd0, 100, 0, 0, 70, 6, i2cm_pkg::WRITE_DEPTH);
    run_session(8'd3, 8'd2, 100, 50, 50, 60, 4, i2cm_pkg::WRITE_DEPTH);
    run_session(8'd2, 8'd255, 100, 20, 10, 95, 6, i2cm_pkg::WRITE_DEPTH);
    run_session(8'd1, 8'd255, 60, 40, 60, 85, 4, i2cm_pkg::WRITE_DEPTH);

    in_valid <= 1'b0;
    while (sb.expected_lines.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_lines.size() != 0) begin
      $error("%0d result words never arrived", sb.expected_lines.size());
    end
    if (sb.errors == 0 && sb.expected_lines.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/i2cm_pkg.sv
rtl/i2c_master_register_access.sv
tb/i2cm_tb_pkg.sv
tb/i2c_master_register_access_tb.sv
